/* hw/rtl/ppfd_pkg.sv */
package ppfd_pkg;

  localparam int unsigned MaxLenDefault = 64;
  localparam int unsigned PeriodW       = 16;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned LenW          = 7;
  localparam int unsigned CfgW          = 16;
  localparam int unsigned RegIdxW       = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_GLITCH_LIMIT    = 3'd0,
    REG_ZERO_ONE_SPLIT  = 3'd1,
    REG_ONE_SYNC_SPLIT  = 3'd2,
    REG_SYNC_IDLE_SPLIT = 3'd3,
    REG_MAX_PAYLOAD     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    SYM_GLITCH,
    SYM_ZERO,
    SYM_ONE,
    SYM_SYNC,
    SYM_IDLE
  } sym_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic step;
    logic rd_start;
    logic rd_fetch;
    logic rd_advance;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic rd_last;
  } dp_status_t;

endpackage

/* hw/rtl/ppfd_ifs.sv */
interface ppfd_period_if;
  logic                          valid;
  logic                          ready;
  logic [ppfd_pkg::PeriodW-1:0]  period;

  modport source (output valid, output period, input ready);
  modport sink   (input valid, input period, output ready);
endinterface

interface ppfd_byte_if;
  logic                        valid;
  logic                        ready;
  logic [ppfd_pkg::ByteW-1:0]  data_byte;
  logic                        last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* hw/rtl/ppfd_datapath.sv */
module ppfd_datapath #(
  parameter int unsigned MAX_LEN = ppfd_pkg::MaxLenDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ppfd_pkg::PeriodW-1:0]  period,
  input  logic                          cfg_write,
  input  logic [ppfd_pkg::RegIdxW-1:0]  cfg_index,
  input  logic [ppfd_pkg::CfgW-1:0]     cfg_data,
  input  ppfd_pkg::dp_cmd_t             cmd,
  output ppfd_pkg::dp_status_t          status,
  output logic [ppfd_pkg::ByteW-1:0]    data_byte,
  output logic                          last_byte
);
  import ppfd_pkg::*;

  localparam int unsigned AddrW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [LenW-1:0] MaxLenL = LenW'(MAX_LEN);

  logic [PeriodW-1:0] glitch_limit;
  logic [PeriodW-1:0] zero_one_split;
  logic [PeriodW-1:0] one_sync_split;
  logic [PeriodW-1:0] sync_idle_split;
  logic [LenW-1:0]    max_payload;

  logic               locked;
  logic [ByteW-1:0]   partial_byte;
  logic [2:0]         bit_count;
  logic [LenW-1:0]    byte_index;
  logic [LenW-1:0]    bytes_needed;

  logic [ByteW-1:0]   mem [MAX_LEN];
  logic [AddrW-1:0]   rd_idx;
  logic [ByteW-1:0]   rdata;
  logic               last_q;

  sym_t               sym;
  logic               is_bit;
  logic               byte_full;
  logic               is_len_byte;
  logic [ByteW-1:0]   assembled;
  logic [LenW-1:0]    limit;
  logic               len_ok;
  logic [LenW-1:0]    index_inc;
  logic [LenW-1:0]    store_idx;
  logic               complete;
  logic               mem_we;
  logic [AddrW-1:0]   wr_addr;

  always_comb begin
    if (period < glitch_limit) begin
      sym = SYM_GLITCH;
    end else if (period < zero_one_split) begin
      sym = SYM_ZERO;
    end else if (period < one_sync_split) begin
      sym = SYM_ONE;
    end else if (period < sync_idle_split) begin
      sym = SYM_SYNC;
    end else begin
      sym = SYM_IDLE;
    end
  end

  always_comb begin
    is_bit      = locked && (sym == SYM_ZERO || sym == SYM_ONE);
    byte_full   = (bit_count == 3'd7);
    is_len_byte = (byte_index == '0);
    assembled   = partial_byte | ((sym == SYM_ONE) ? (ByteW'(1) << bit_count) : '0);
    limit       = (max_payload < MaxLenL) ? max_payload : MaxLenL;
    len_ok      = (assembled != '0) && ({1'b0, limit} >= assembled);
    index_inc   = byte_index + 7'd1;
    store_idx   = byte_index - 7'd1;
    complete    = is_bit && byte_full && !is_len_byte && (bytes_needed != '0)
                  && (index_inc >= bytes_needed);
    mem_we      = cmd.step && is_bit && byte_full && !is_len_byte && (store_idx < MaxLenL);
    wr_addr     = AddrW'(store_idx);
  end

  assign status.frame_done = complete;
  assign status.rd_last    = last_q;
  assign data_byte         = rdata;
  assign last_byte         = last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      glitch_limit    <= 16'd100;
      zero_one_split  <= 16'd300;
      one_sync_split  <= 16'd500;
      sync_idle_split <= 16'd800;
      max_payload     <= 7'd64;
      locked          <= 1'b0;
      partial_byte    <= '0;
      bit_count       <= '0;
      byte_index      <= '0;
      bytes_needed    <= '0;
      rd_idx          <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_GLITCH_LIMIT:    glitch_limit    <= cfg_data;
          REG_ZERO_ONE_SPLIT:  zero_one_split  <= cfg_data;
          REG_ONE_SYNC_SPLIT:  one_sync_split  <= cfg_data;
          REG_SYNC_IDLE_SPLIT: sync_idle_split <= cfg_data;
          REG_MAX_PAYLOAD:     max_payload     <= cfg_data[LenW-1:0];
          default: ;
        endcase
      end
      if (cmd.step) begin
        if (sym == SYM_SYNC) begin
          locked       <= 1'b1;
          partial_byte <= '0;
          bit_count    <= '0;
          byte_index   <= '0;
          bytes_needed <= '0;
        end else if (sym == SYM_GLITCH || sym == SYM_IDLE) begin
          locked <= 1'b0;
        end else if (locked) begin
          if (!byte_full) begin
            partial_byte <= assembled;
            bit_count    <= bit_count + 3'd1;
          end else begin
            partial_byte <= '0;
            bit_count    <= '0;
            if (is_len_byte && !len_ok) begin
              locked <= 1'b0;
            end else begin
              if (is_len_byte) begin
                bytes_needed <= LenW'(assembled) + 7'd1;
              end
              byte_index <= index_inc;
              if (complete) begin
                locked <= 1'b0;
              end
            end
          end
        end
      end
      if (cmd.rd_start) begin
        rd_idx <= '0;
      end else if (cmd.rd_advance) begin
        rd_idx <= rd_idx + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= assembled;
    end
    if (cmd.rd_fetch) begin
      rdata  <= mem[rd_idx];
      last_q <= (LenW'(rd_idx) == (bytes_needed - 7'd2));
    end
  end

endmodule

/* hw/rtl/ppfd_ctrl.sv */
module ppfd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  out_ready,
  input  ppfd_pkg::dp_status_t  status,
  output ppfd_pkg::dp_cmd_t     cmd,
  output logic                  in_ready,
  output logic                  out_valid
);
  import ppfd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && status.frame_done) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready) begin
          state_next = status.rd_last ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd.step       = 1'b0;
    cmd.rd_start   = 1'b0;
    cmd.rd_fetch   = 1'b0;
    cmd.rd_advance = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.step     = in_valid;
        cmd.rd_start = in_valid && status.frame_done;
      end
      ST_FETCH: begin
        cmd.rd_fetch = 1'b1;
      end
      ST_HOLD: begin
        out_valid      = 1'b1;
        cmd.rd_advance = out_ready && !status.rd_last;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/pulse_period_frame_decoder.sv */
// Pulse distance frame decoder.
// pulses carries one measured fall-to-fall period per beat. Each period is
// classed against the four threshold registers as glitch, bit zero, bit one,
// sync or idle. A sync locks the decoder; bits are packed LSB first, the first
// byte is the payload length, and the payload bytes go to a local memory.
// When the last payload byte of a frame arrives, the frame is sent on payload
// as one beat per byte, last_byte set on the final one.
// While no frame is being sent, pulses.ready is high and each period is taken
// as it arrives. After the period that ends a frame, each payload byte goes
// through a registered memory read, then a hold; pulses.ready stays low until
// the final byte is taken. A stalled receiver holds the current byte steady;
// nothing is dropped. Registers are written via cfg_write/cfg_index/cfg_data;
// the user must write them only while idle; the block does not enforce it.
// Reset (rst, synchronous) restores threshold defaults, returns to hunting and
// clears byte assembly; payload memory keeps no reset.
module pulse_period_frame_decoder #(
  parameter int unsigned MAX_LEN = ppfd_pkg::MaxLenDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  ppfd_period_if.sink                   pulses,
  ppfd_byte_if.source                   payload,
  input  logic                          cfg_write,
  input  logic [ppfd_pkg::RegIdxW-1:0]  cfg_index,
  input  logic [ppfd_pkg::CfgW-1:0]     cfg_data
);
  import ppfd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ppfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pulses.valid),
    .out_ready (payload.ready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (pulses.ready),
    .out_valid (payload.valid)
  );

  ppfd_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .period    (pulses.period),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .data_byte (payload.data_byte),
    .last_byte (payload.last_byte)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(payload.valid && pulses.ready))
    else $error("input ready while a frame byte is pending");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    payload.valid && payload.ready && payload.last_byte |=> pulses.ready)
    else $error("input not ready after final frame byte");

  a_mid_frame_busy: assert property (@(posedge clk) disable iff (rst)
    payload.valid && payload.ready && !payload.last_byte |=> !pulses.ready)
    else $error("input ready in the middle of a frame");

endmodule
